// File: design/sse_pkg.sv
package sse_pkg;

   localparam int LANES = 16;
   localparam int PIX_W = 8;
   localparam int SQ_W = 2 * PIX_W;
   localparam int GROUP = 4;
   localparam int GROUPS = (LANES + GROUP - 1) / GROUP;
   localparam int GROUP_SUM_W = SQ_W + $clog2(GROUP);
   localparam int ROW_SUM_W = SQ_W + $clog2(LANES);
   localparam int TOTAL_W = 24;
   localparam int COUNT_W = 4;
   localparam int SHAPE_W = 2;

   typedef enum logic [SHAPE_W-1:0] {
      SHAPE_16X16 = 2'd0,
      SHAPE_16X8  = 2'd1,
      SHAPE_8X8   = 2'd2,
      SHAPE_4X4   = 2'd3
   } shape_type;

   typedef logic [PIX_W-1:0] pixel_type;
   typedef logic [SQ_W-1:0] square_type;

   typedef struct packed {
      logic valid;
      logic last_row;
   } stage_ctl_type;

   // Index of the final row of a block for the given shape.
   function automatic logic [COUNT_W-1:0] last_row_fn(input shape_type shape);
      logic [COUNT_W-1:0] result;
      case (shape)
         SHAPE_16X16: result = COUNT_W'(15);
         SHAPE_16X8:  result = COUNT_W'(7);
         SHAPE_8X8:   result = COUNT_W'(7);
         SHAPE_4X4:   result = COUNT_W'(3);
         default:     result = COUNT_W'(15);
      endcase
      return result;
   endfunction

   function automatic logic lane_active_fn(input shape_type shape, input int lane);
      logic result;
      case (shape)
         SHAPE_16X16: result = 1'b1;
         SHAPE_16X8:  result = 1'b1;
         SHAPE_8X8:   result = (lane < 8);
         SHAPE_4X4:   result = (lane < 4);
         default:     result = 1'b1;
      endcase
      return result;
   endfunction

endpackage

// File: design/sse_lane.sv
module sse_lane (
   input  logic               clock,
   input  logic               enable,
   input  logic               active,
   input  sse_pkg::pixel_type src_pixel,
   input  sse_pkg::pixel_type ref_pixel,
   output sse_pkg::square_type square
);

   sse_pkg::pixel_type  diff;
   sse_pkg::square_type square_ff;
   sse_pkg::square_type square_in;

   always_comb begin
      diff = (src_pixel > ref_pixel) ? (src_pixel - ref_pixel) : (ref_pixel - src_pixel);
      // Lanes outside the block shape contribute nothing to the row sum.
      square_in = active ? (sse_pkg::SQ_W'(diff) * sse_pkg::SQ_W'(diff)) : '0;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         square_ff <= square_in;
      end
   end

   assign square = square_ff;

endmodule

// File: design/sse_merge.sv
module sse_merge (
   input  logic                         clock,
   input  logic                         reset,
   input  sse_pkg::stage_ctl_type       ctl,
   input  sse_pkg::square_type          squares [sse_pkg::LANES],
   output logic                         advance,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [sse_pkg::TOTAL_W-1:0]  rsp_squared_error_total
);

   logic [sse_pkg::GROUP_SUM_W-1:0] group_sum_ff [sse_pkg::GROUPS];
   logic [sse_pkg::GROUP_SUM_W-1:0] group_sum_in [sse_pkg::GROUPS];
   sse_pkg::stage_ctl_type          ctl2_ff;
   logic [sse_pkg::ROW_SUM_W-1:0]   row_sum_ff;
   logic [sse_pkg::ROW_SUM_W-1:0]   row_sum_in;
   sse_pkg::stage_ctl_type          ctl3_ff;
   logic [sse_pkg::TOTAL_W-1:0]     acc_ff;
   logic [sse_pkg::TOTAL_W-1:0]     acc_sum;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [sse_pkg::TOTAL_W-1:0]     rsp_total_ff;
   logic                            out_free;
   logic                            go3;
   logic                            en3;
   logic                            en2;

   always_comb begin
      for (int g = 0; g < sse_pkg::GROUPS; g++) begin
         group_sum_in[g] = '0;
         for (int j = 0; j < sse_pkg::GROUP; j++) begin
            if (g * sse_pkg::GROUP + j < sse_pkg::LANES) begin
               group_sum_in[g] = group_sum_in[g]
                  + sse_pkg::GROUP_SUM_W'(squares[g * sse_pkg::GROUP + j]);
            end
         end
      end
   end

   always_comb begin
      row_sum_in = '0;
      for (int g = 0; g < sse_pkg::GROUPS; g++) begin
         row_sum_in = row_sum_in + sse_pkg::ROW_SUM_W'(group_sum_ff[g]);
      end
   end

   // A final row may leave the accumulator only when the output register can take it.
   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      go3 = ctl3_ff.valid && (!ctl3_ff.last_row || out_free);
      en3 = !ctl3_ff.valid || go3;
      en2 = !ctl2_ff.valid || en3;
      acc_sum = acc_ff + sse_pkg::TOTAL_W'(row_sum_ff);
      if (go3 && ctl3_ff.last_row) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         acc_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en2) begin
            ctl2_ff <= ctl;
         end
         if (en3) begin
            ctl3_ff <= ctl2_ff;
         end
         if (go3) begin
            acc_ff <= ctl3_ff.last_row ? '0 : acc_sum;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         group_sum_ff <= group_sum_in;
      end
      if (en3) begin
         row_sum_ff <= row_sum_in;
      end
      if (go3 && ctl3_ff.last_row) begin
         rsp_total_ff <= acc_sum;
      end
   end

   assign advance = en2;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_squared_error_total = rsp_total_ff;

`ifndef SYNTHESIS
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      go3 && ctl3_ff.last_row |=> rsp_valid_ff && (acc_ff == '0))
      else $error("accumulator not cleared after final row");
   a_hold_full: assert property (@(posedge clock) disable iff (reset)
      !advance |-> ctl2_ff.valid && ctl3_ff.valid)
      else $error("pipeline held back while not full");
`endif

endmodule

// File: design/block_sum_squared_error_unit.sv
// A final-row total passes the lane square, group sum, row sum and output registers to rsp.
// Throughput: one request per cycle unless a final row is held by a stalled rsp,
// set by the lane squaring stage and the two-level adder tree feeding the accumulator.
// A final row waits in the accumulator stage while an earlier total is stalled on rsp.
// Reset (synchronous, active high) clears the total, the row count, the pipeline and
// sets the block shape to 16x16.
module block_sum_squared_error_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [63:0]                 req_src_pixels_low,
   input  logic [63:0]                 req_src_pixels_high,
   input  logic [63:0]                 req_ref_pixels_low,
   input  logic [63:0]                 req_ref_pixels_high,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [sse_pkg::TOTAL_W-1:0] rsp_squared_error_total,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [sse_pkg::SHAPE_W-1:0] csr_block_shape
);

   sse_pkg::shape_type            shape_ff;
   logic [sse_pkg::COUNT_W-1:0]   row_count_ff;
   logic [sse_pkg::COUNT_W-1:0]   row_count_in;
   sse_pkg::stage_ctl_type        ctl1_ff;
   sse_pkg::stage_ctl_type        ctl1_in;
   logic                          en1;
   logic                          advance;
   logic                          accept;
   logic                          is_last;
   sse_pkg::pixel_type            src_pix [sse_pkg::LANES];
   sse_pkg::pixel_type            ref_pix [sse_pkg::LANES];
   sse_pkg::square_type           squares [sse_pkg::LANES];

   for (genvar k = 0; k < sse_pkg::LANES; k++) begin : g_lane
      if (k < 8) begin : g_low
         assign src_pix[k] = req_src_pixels_low[sse_pkg::PIX_W*k +: sse_pkg::PIX_W];
         assign ref_pix[k] = req_ref_pixels_low[sse_pkg::PIX_W*k +: sse_pkg::PIX_W];
      end else begin : g_high
         assign src_pix[k] = req_src_pixels_high[sse_pkg::PIX_W*(k-8) +: sse_pkg::PIX_W];
         assign ref_pix[k] = req_ref_pixels_high[sse_pkg::PIX_W*(k-8) +: sse_pkg::PIX_W];
      end
      sse_lane u_lane (
         .clock     (clock),
         .enable    (en1),
         .active    (sse_pkg::lane_active_fn(shape_ff, k)),
         .src_pixel (src_pix[k]),
         .ref_pixel (ref_pix[k]),
         .square    (squares[k])
      );
   end

   // The row position is known when the request arrives, so the final-row flag
   // travels down the pipeline with the data.
   always_comb begin
      en1 = !ctl1_ff.valid || advance;
      accept = req_valid && en1;
      is_last = (row_count_ff >= sse_pkg::last_row_fn(shape_ff));
      row_count_in = row_count_ff;
      if (accept) begin
         row_count_in = is_last ? '0 : row_count_ff + 1'b1;
      end
      ctl1_in = ctl1_ff;
      if (en1) begin
         ctl1_in.valid = req_valid;
         ctl1_in.last_row = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff <= sse_pkg::SHAPE_16X16;
         row_count_ff <= '0;
         ctl1_ff <= '0;
      end else begin
         if (csr_valid) begin
            shape_ff <= sse_pkg::shape_type'(csr_block_shape);
         end
         row_count_ff <= row_count_in;
         ctl1_ff <= ctl1_in;
      end
   end

   sse_merge u_merge (
      .clock                   (clock),
      .reset                   (reset),
      .ctl                     (ctl1_ff),
      .squares                 (squares),
      .advance                 (advance),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_squared_error_total (rsp_squared_error_total)
   );

   assign req_stall = !en1;
   assign csr_ready = 1'b1;

`ifndef SYNTHESIS
   a_count_wraps: assert property (@(posedge clock) disable iff (reset)
      accept && is_last |=> row_count_ff == '0)
      else $error("row count not cleared after final row");
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ctl1_ff.valid && !advance)
      else $error("request stalled with room in the pipeline");
`endif

endmodule

// File: tb/tb_top.sv
module tb_top;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int SEGMENTS = 8;
   localparam int SEGMENT_ROWS = 194;

   typedef struct packed {
      logic [127:0] src_row;
      logic [127:0] ref_row;
   } row_pair_type;

   typedef struct packed {
      bit                 set_shape;
      sse_pkg::shape_type shape;
      int                 rows;
      logic [127:0]       src_row;
      logic [127:0]       ref_row;
      bit                 typed;
      logic [23:0]        total;
   } plan_step_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_src_pixels_low = '0;
   logic [63:0] req_src_pixels_high = '0;
   logic [63:0] req_ref_pixels_low = '0;
   logic [63:0] req_ref_pixels_high = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [sse_pkg::TOTAL_W-1:0] rsp_squared_error_total;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [sse_pkg::SHAPE_W-1:0] csr_block_shape = sse_pkg::SHAPE_16X16;

   // A directed row may carry a total typed into the plan; it rides with the payload.
   logic                        fixed_total_on = 1'b0;
   logic [sse_pkg::TOTAL_W-1:0] fixed_total = '0;

   sse_pkg::shape_type          shape_now = sse_pkg::SHAPE_16X16;
   logic [sse_pkg::TOTAL_W-1:0] block_total = '0;
   logic [sse_pkg::COUNT_W-1:0] row_index = '0;
   logic [sse_pkg::TOTAL_W-1:0] totals_due[$];
   logic [sse_pkg::TOTAL_W-1:0] due_total;

   int errors = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   plan_step_type directed_plan [5];

   block_sum_squared_error_unit dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_src_pixels_low      (req_src_pixels_low),
      .req_src_pixels_high     (req_src_pixels_high),
      .req_ref_pixels_low      (req_ref_pixels_low),
      .req_ref_pixels_high     (req_ref_pixels_high),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_squared_error_total (rsp_squared_error_total),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_block_shape         (csr_block_shape)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count == CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);
   end

   // Squared error of one row over the lanes that the shape enables.
   function automatic logic [sse_pkg::TOTAL_W-1:0] row_error(
         input sse_pkg::shape_type shape,
         input logic [127:0] src_row,
         input logic [127:0] ref_row);
      int lanes;
      int diff;
      logic [sse_pkg::TOTAL_W-1:0] acc;
      case (shape)
         sse_pkg::SHAPE_16X16, sse_pkg::SHAPE_16X8: lanes = sse_pkg::LANES;
         sse_pkg::SHAPE_8X8: lanes = (sse_pkg::LANES < 8) ? sse_pkg::LANES : 8;
         default:            lanes = 4;
      endcase
      acc = '0;
      for (int k = 0; k < lanes; k++) begin
         diff = int'(src_row[8*k +: 8]) - int'(ref_row[8*k +: 8]);
         acc = acc + sse_pkg::TOTAL_W'(diff * diff);
      end
      return acc;
   endfunction

   task automatic accumulate_row(input logic [127:0] src_row, input logic [127:0] ref_row);
      logic [sse_pkg::COUNT_W-1:0] last_index;
      case (shape_now)
         sse_pkg::SHAPE_16X16:                    last_index = 4'd15;
         sse_pkg::SHAPE_16X8, sse_pkg::SHAPE_8X8: last_index = 4'd7;
         default:                                 last_index = 4'd3;
      endcase
      block_total = block_total + row_error(shape_now, src_row, ref_row);
      // A shape change can leave the count past the new final row; it closes the block.
      if (row_index >= last_index) begin
         totals_due.push_back(fixed_total_on ? fixed_total : block_total);
         block_total = '0;
         row_index = '0;
      end else begin
         row_index = row_index + 1'b1;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            accumulate_row({req_src_pixels_high, req_src_pixels_low},
                           {req_ref_pixels_high, req_ref_pixels_low});
         end
         if (rsp_valid && !rsp_stall) begin
            if (totals_due.size() == 0) begin
               $display("%0t: unexpected total: expected none, got %0d",
                        $time, rsp_squared_error_total);
               errors++;
            end else begin
               due_total = totals_due.pop_front();
               if (rsp_squared_error_total !== due_total) begin
                  $display("%0t: squared error total mismatch: expected %0d, got %0d",
                           $time, due_total, rsp_squared_error_total);
                  errors++;
               end
            end
         end
      end
   end

   function automatic row_pair_type random_row();
      row_pair_type r;
      r.src_row = {$urandom, $urandom, $urandom, $urandom};
      r.ref_row = {$urandom, $urandom, $urandom, $urandom};
      case ($urandom_range(3))
         1: begin
            for (int k = 0; k < 16; k++) begin
               r.src_row[8*k +: 8] = {8{r.src_row[8*k]}};
               r.ref_row[8*k +: 8] = {8{r.ref_row[8*k]}};
            end
         end
         2: r.ref_row = r.src_row;
         3: begin
            for (int k = 0; k < 16; k++) begin
               r.ref_row[8*k +: 8] = r.src_row[8*k +: 8] + 8'($urandom_range(6)) - 8'd3;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_row(input row_pair_type row, input bit typed,
                           input logic [sse_pkg::TOTAL_W-1:0] total, input bit drain);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
      if (drain && gap == 0) gap = 1;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (drain) begin
         while (totals_due.size() != 0) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_src_pixels_low <= row.src_row[63:0];
      req_src_pixels_high <= row.src_row[127:64];
      req_ref_pixels_low <= row.ref_row[63:0];
      req_ref_pixels_high <= row.ref_row[127:64];
      fixed_total_on <= typed;
      fixed_total <= total;
      do @(posedge clock); while (req_stall);
   endtask

   // Rows that end no block may still be in the pipeline once the last total is in.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (totals_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_shape(input sse_pkg::shape_type shape);
      csr_valid <= 1'b1;
      csr_block_shape <= shape;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shape_now = shape;
   endtask

   initial begin
      sse_pkg::shape_type seg_shape;
      row_pair_type row;

      directed_plan = '{
         // Full 16x16 block at the largest difference gives the largest total.
         '{1'b0, sse_pkg::SHAPE_16X16, 16, {128{1'b1}}, 128'd0, 1'b1, 24'd16646400},
         '{1'b1, sse_pkg::SHAPE_4X4, 4,
           {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FF00_0003},
           {64'h0000_0000_0000_0000, 64'h0000_0000_0000_0700}, 1'b1, 24'd260332},
         '{1'b1, sse_pkg::SHAPE_8X8, 3,
           {64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF},
           {64'h0000_0000_0000_0000, 64'hFEDC_BA98_7654_3210}, 1'b0, 24'd0},
         // Switching to 4x4 three rows into an 8x8 block makes the next row final.
         '{1'b1, sse_pkg::SHAPE_4X4, 1,
           {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_8000_FF01},
           {64'h0000_0000_0000_0000, 64'h0000_0000_7FFF_00FE}, 1'b0, 24'd0},
         '{1'b0, sse_pkg::SHAPE_4X4, 4,
           {64'hFFFF_FFFF_FFFF_FFFF, 64'h5A5A_5A5A_5A5A_5A5A},
           {64'h0000_0000_0000_0000, 64'h5A5A_5A5A_5A5A_5A5A}, 1'b1, 24'd0}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].set_shape) begin
            wait_idle();
            write_shape(directed_plan[i].shape);
         end
         for (int r = 0; r < directed_plan[i].rows; r++) begin
            row.src_row = directed_plan[i].src_row;
            row.ref_row = directed_plan[i].ref_row;
            send_row(row, directed_plan[i].typed && (r == directed_plan[i].rows - 1),
                     directed_plan[i].total, 1'b0);
         end
      end

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg / 2)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 58; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 58; end
            default: begin send_idle_pct = 15; rsp_stall_pct = 15; end
         endcase
         case (seg)
            0: seg_shape = sse_pkg::SHAPE_16X16;
            1: seg_shape = sse_pkg::SHAPE_4X4;
            2: seg_shape = sse_pkg::SHAPE_16X8;
            3: seg_shape = sse_pkg::SHAPE_8X8;
            default: seg_shape = sse_pkg::shape_type'($urandom_range(3));
         endcase
         // Segments can end mid-block, so a shape write can also land inside a block.
         wait_idle();
         write_shape(seg_shape);
         for (int n = 0; n < SEGMENT_ROWS; n++) begin
            send_row(random_row(), 1'b0, '0, (seg % 2 == 1) && ($urandom_range(29) == 0));
         end
      end

      req_valid <= 1'b0;
      while (totals_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: block_sum_squared_error_unit.f
design/sse_pkg.sv
design/sse_lane.sv
design/sse_merge.sv
design/block_sum_squared_error_unit.sv
tb/tb_top.sv
